FILE: rtl/lasf_pkg.sv
// Shared types and constants for the local alignment score fill block.
// No dependencies; used by every module under rtl/.
package lasf_pkg;

    localparam int SCORE_W    = 14;
    localparam int WORD_W     = 32;
    localparam int CFG_DATA_W = 5;
    localparam int SUM_W      = 16;

    localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [3:0] MATCH_RST    = 4'd4;
    localparam logic [4:0] MISMATCH_RST = 5'b11110;  // -2
    localparam logic [4:0] LEFT_GAP_RST = 5'b11111;  // -1
    localparam logic [4:0] UP_GAP_RST   = 5'b11101;  // -3

    typedef enum logic [1:0] {
        REG_MATCH,
        REG_MISMATCH,
        REG_LEFT_GAP,
        REG_UP_GAP
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]        match_score;
        logic signed [4:0] mismatch_score;
        logic signed [4:0] left_gap_score;
        logic signed [4:0] up_gap_score;
    } score_cfg_t;

    typedef struct packed {
        logic first_row;
        logic words_equal;
        logic row_end;
        logic overflow;
    } cell_flags_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: rtl/lasf_queue.sv
// Small register queue between the front and back parts.
// Depends on lasf_pkg for depth and status types.
module lasf_queue #(
    parameter int WIDTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        head_data,
    output lasf_pkg::queue_status_t status
);
    import lasf_pkg::*;

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: rtl/lasf_front.sv
// Front part: takes input words, tracks the column and classifies each cell.
// Depends on lasf_pkg; feeds lasf_queue.
module lasf_front #(
    parameter int MAX_COLUMNS = 1024,
    parameter int AW          = 10,
    parameter int PW          = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*lasf_pkg::WORD_W-1:0] s_tdata,
    input  logic                    s_tlast,
    input  logic                    s_tuser,
    input  logic                    queue_full,
    output logic                    push,
    output lasf_pkg::cell_flags_t   push_flags,
    output logic [AW-1:0]           push_addr
);
    import lasf_pkg::*;

    logic [PW-1:0] pos_reg, pos_next;
    logic          over;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;
    assign over     = (pos_reg >= PW'(MAX_COLUMNS));

    assign push_flags.first_row   = s_tuser;
    assign push_flags.words_equal = (s_tdata[WORD_W-1:0] == s_tdata[2*WORD_W-1:WORD_W]);
    assign push_flags.row_end     = s_tlast;
    assign push_flags.overflow    = over;
    // keep the address inside the store for overflow cells
    assign push_addr = over ? '0 : pos_reg[AW-1:0];

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (s_tlast)
            begin
                pos_next = '0;
            end
            else if (!over)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/lasf_back.sv
// Back part: row store read, cell score recurrence and output register.
// Depends on lasf_pkg; pops cells from lasf_queue.
module lasf_back #(
    parameter int MAX_COLUMNS = 1024,
    parameter int AW          = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lasf_pkg::score_cfg_t  cfg,
    input  logic                  head_valid,
    input  lasf_pkg::cell_flags_t head_flags,
    input  logic [AW-1:0]         head_addr,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);
    import lasf_pkg::*;

    logic [SCORE_W-1:0] row_mem_reg [MAX_COLUMNS];

    logic               b_valid_reg, b_valid_next;
    cell_flags_t        b_flags_reg;
    logic [AW-1:0]      b_addr_reg;
    logic [SCORE_W-1:0] rd_q_reg;
    logic               fwd_reg;
    logic [SCORE_W-1:0] fwd_data_reg;

    logic [SCORE_W-1:0] left_reg, left_next;
    logic [SCORE_W-1:0] diag_reg, diag_next;

    logic               out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_last_reg;
    logic               out_over_reg;

    logic               b_fire;
    logic               b_wen;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] score;

    assign b_fire = b_valid_reg && (!out_valid_reg || m_tready);
    assign pop    = head_valid && (!b_valid_reg || b_fire);
    assign b_wen  = b_fire && !b_flags_reg.overflow;

    // up value: the cell just ahead may be writing this column in the read cycle
    always_comb
    begin
        if (b_flags_reg.first_row)
        begin
            up = '0;
        end
        else if (fwd_reg)
        begin
            up = fwd_data_reg;
        end
        else
        begin
            up = rd_q_reg;
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] diag_add;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] best;
        diag_add = b_flags_reg.words_equal
                 ? $signed({{(SUM_W-4){1'b0}}, cfg.match_score})
                 : SUM_W'(cfg.mismatch_score);
        a = $signed({{(SUM_W-SCORE_W){1'b0}}, left_reg}) + SUM_W'(cfg.left_gap_score);
        b = $signed({{(SUM_W-SCORE_W){1'b0}}, up}) + SUM_W'(cfg.up_gap_score);
        c = $signed({{(SUM_W-SCORE_W){1'b0}}, diag_reg}) + diag_add;
        best = '0;
        if (a > best)
        begin
            best = a;
        end
        if (b > best)
        begin
            best = b;
        end
        if (c > best)
        begin
            best = c;
        end
        if (b_flags_reg.overflow)
        begin
            score = '0;
        end
        else if (best > $signed({{(SUM_W-SCORE_W){1'b0}}, SCORE_TOP}))
        begin
            score = SCORE_TOP;
        end
        else
        begin
            score = best[SCORE_W-1:0];
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (pop)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end

        left_next = left_reg;
        diag_next = diag_reg;
        if (b_fire)
        begin
            if (b_flags_reg.row_end)
            begin
                left_next = '0;
                diag_next = '0;
            end
            else if (!b_flags_reg.overflow)
            begin
                left_next = score;
                diag_next = up;
            end
        end

        out_valid_next = out_valid_reg;
        if (b_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // row store: one write from the score stage, one registered read on pop
    always_ff @(posedge clk)
    begin
        if (b_wen)
        begin
            row_mem_reg[b_addr_reg] <= score;
        end
        if (pop)
        begin
            rd_q_reg <= row_mem_reg[head_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_flags_reg  <= head_flags;
            b_addr_reg   <= head_addr;
            fwd_reg      <= b_wen && (b_addr_reg == head_addr);
            fwd_data_reg <= score;
        end
        if (b_fire)
        begin
            out_score_reg <= score;
            out_last_reg  <= b_flags_reg.row_end;
            out_over_reg  <= b_flags_reg.overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-SCORE_W){1'b0}}, out_score_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_over_reg;

endmodule

FILE: rtl/local_alignment_score_fill.sv
// Top level of the local alignment (Smith-Waterman, linear gap) score fill.
// Depends on lasf_pkg, lasf_front, lasf_queue and lasf_back.
//
// Usage:
//   Slave stream: one word per matrix cell, row-major order. s_tdata carries
//   the two word identifiers, s_tlast ends a row, s_tuser marks cells of a
//   document's first row (row above reads as zero).
//   Master stream: one word per cell with its score, the row-end copy in
//   m_tlast and the column overflow flag in m_tuser (score then zero).
//   Config port: cfg_we/cfg_index/cfg_data write the four score registers;
//   write only while no cell is in flight.
// Timing:
//   One word per cycle sustained while m_tready stays high. Path from accept to
//   m_tvalid: queue slot, pop with row store read, then score register. The
//   score stage holds the left score loop through add and three-way max.
// Reset: clears column position, left/diagonal scores, queue and valids and
//   loads the default scores; the row store is not cleared.
// Stall: a held m_tready freezes the back part; the queue fills and then
//   s_tready drops. No word is lost or repeated.
module local_alignment_score_fill #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // query_word, reference_word
    input  logic                                s_tlast,   // row_end
    input  logic                                s_tuser,   // first_row
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // cell_score, 2 pad bits
    output logic                                m_tlast,   // last_in_row
    output logic                                m_tuser,   // column_overflow
    input  logic                                cfg_we,
    input  lasf_pkg::cfg_index_t                cfg_index,
    input  logic [lasf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lasf_pkg::*;

    localparam int AW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PW   = $clog2(MAX_COLUMNS + 1);
    localparam int QW   = $bits(cell_flags_t) + AW;

    score_cfg_t    cfg_reg, cfg_next;
    queue_status_t q_status;

    logic          push;
    cell_flags_t   push_flags;
    logic [AW-1:0] push_addr;
    logic          pop;
    cell_flags_t   head_flags;
    logic [AW-1:0] head_addr;
    logic [QW-1:0] head_data;

    // score registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATCH:    cfg_next.match_score    = cfg_data[3:0];
                REG_MISMATCH: cfg_next.mismatch_score = cfg_data;
                REG_LEFT_GAP: cfg_next.left_gap_score = cfg_data;
                REG_UP_GAP:   cfg_next.up_gap_score   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_score    <= MATCH_RST;
            cfg_reg.mismatch_score <= MISMATCH_RST;
            cfg_reg.left_gap_score <= LEFT_GAP_RST;
            cfg_reg.up_gap_score   <= UP_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify
    lasf_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .AW          (AW),
        .PW          (PW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .queue_full (q_status.full),
        .push       (push),
        .push_flags (push_flags),
        .push_addr  (push_addr)
    );

    // decoupling queue
    lasf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flags, push_addr}),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    assign head_flags = head_data[QW-1:AW];
    assign head_addr  = head_data[AW-1:0];

    // back: score recurrence and output register
    lasf_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .AW          (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (!q_status.empty),
        .head_flags (head_flags),
        .head_addr  (head_addr),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

`ifndef SYNTHESIS
    // overflow cells always carry a zero score
    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("overflow cell with nonzero score");

    // the queue cannot be full and empty at once
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_status.empty)
        else $error("queue status inconsistent");

    // input is refused only when the queue is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_status.full)
        else $error("input stalled with room in queue");

    // nothing is popped from an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule
